### rtl/core/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the byte ring buffer with peek and drop.
// ----------------------------------------------------------------------------
package brb_pkg;

   // Storage geometry
   localparam int unsigned DEPTH  = 256;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

   // Request codes carried on req_tuser
   typedef enum logic [1:0] {
      REQ_APPEND = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_PEEK   = 2'd2
   } req_kind_type;

   // Access to the byte store issued by the pointer control
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } store_cmd_type;

   // Status of one request after the pointer update
   typedef struct packed {
      logic             peek;
      logic [CNT_W-1:0] fill;
      logic             full;
      logic             dropped;
   } req_status_type;

endpackage

### rtl/core/byte_ring_buffer_peek_drop.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_peek_drop
// Byte ring buffer with append, delete-from-head and peek requests.
// ----------------------------------------------------------------------------
// One request is taken per clock unless the response path stalls, and each
// yields one response. Pointers update in the cycle of the transfer; a peek
// reads the byte store through its registered port, a stage holds the
// status alongside that read, and an output register holds the response
// so the next request is taken while it waits. Appends to a full buffer
// are dropped and flagged; the store reads as zero until written after
// reset, with no clearing pass.
module byte_ring_buffer_peek_drop (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // data_byte[7:0], delete_count[16:8],
                                   // read_offset[24:17], zero[31:25]
   input  logic [1:0]  req_tuser,  // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // read_byte[7:0], fill_level[16:8],
                                   // is_full[17], write_dropped[18], zero[23:19]
);
   import brb_pkg::*;

   logic           accept;
   logic           s1_go;
   store_cmd_type  cmd;
   req_status_type status;
   logic [7:0]     rd_byte;

   logic           s1_valid_ff;
   req_status_type s1_status_ff;
   logic           rsp_valid_ff;
   logic [23:0]    rsp_data_ff, rsp_data_in;

   // Move stage one forward when the output register is empty or being read
   assign s1_go      = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   brb_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_kind     (req_tuser),
      .data_byte    (req_tdata[7:0]),
      .delete_count (req_tdata[16:8]),
      .read_offset  (req_tdata[24:17]),
      .cmd          (cmd),
      .status       (status)
   );

   brb_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_byte (rd_byte)
   );

   // Hold status while the store read completes
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= status;
      end
   end

   // Pack the response
   assign rsp_data_in = {5'd0,
                         s1_status_ff.dropped,
                         s1_status_ff.full,
                         s1_status_ff.fill,
                         s1_status_ff.peek ? rd_byte : 8'd0};

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/core/brb_store.sv
// ----------------------------------------------------------------------------
// brb_store
// Byte store: one write and one registered read per cycle. Entries never
// written since reset read as zero through a row of valid bits.
// ----------------------------------------------------------------------------
module brb_store (
   input  logic                   clock,
   input  logic                   reset,
   input  brb_pkg::store_cmd_type cmd,
   output logic [7:0]             rd_byte
);
   import brb_pkg::*;

   logic [7:0]       mem [DEPTH];
   logic [DEPTH-1:0] written_ff;
   logic [7:0]       rdata_ff;
   logic             rvalid_ff;

   // Write and read the byte array
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[cmd.rd_addr];
      end
   end

   // Track entries written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         rvalid_ff  <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            written_ff[cmd.wr_addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rvalid_ff <= written_ff[cmd.rd_addr];
         end
      end
   end

   // Mask never-written entries to the cleared value
   assign rd_byte = rvalid_ff ? rdata_ff : 8'd0;

endmodule

### rtl/core/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Head, tail and level pointers. Decodes one request per transfer, issues
// the store access and reports the level after the update.
// ----------------------------------------------------------------------------
module brb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [1:0]              req_kind,
   input  logic [7:0]              data_byte,
   input  logic [8:0]              delete_count,
   input  logic [7:0]              read_offset,
   output brb_pkg::store_cmd_type  cmd,
   output brb_pkg::req_status_type status
);
   import brb_pkg::*;

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              dropped;
   logic              is_peek;
   logic [CNT_W-1:0]  del_cnt;

   assign del_cnt = CNT_W'(delete_count);

   // Decode the request and compute next pointers
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      dropped     = 1'b0;
      is_peek     = 1'b0;
      cmd.wr_en   = 1'b0;
      cmd.wr_addr = tail_ff;
      cmd.wr_data = data_byte;
      cmd.rd_en   = 1'b0;
      cmd.rd_addr = head_ff + ADDR_W'(read_offset);
      case (req_kind_type'(req_kind))
         REQ_APPEND: begin
            if (count_ff == CNT_W'(DEPTH)) begin
               dropped = 1'b1;
            end else begin
               cmd.wr_en = accept;
               tail_in   = tail_ff + 1'b1;
               count_in  = count_ff + 1'b1;
            end
         end
         REQ_DELETE: begin
            if (del_cnt >= count_ff) begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end else begin
               head_in  = head_ff + del_cnt[ADDR_W-1:0];
               count_in = count_ff - del_cnt;
            end
         end
         REQ_PEEK: begin
            is_peek   = 1'b1;
            cmd.rd_en = accept;
         end
         default: begin
         end
      endcase
   end

   assign status.peek    = is_peek;
   assign status.fill    = count_in;
   assign status.full    = (count_in == CNT_W'(DEPTH));
   assign status.dropped = dropped;

   // Advance pointers on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule
